// ===== src/assert_macros.svh =====
// Assertion helpers shared by the RTL.
// Each module that asserts provides clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset
`define IPV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included
`define IPV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/ipv_pkg.sv =====
`default_nettype none

package ipv_pkg;

  // Item opcodes
  typedef enum logic {
    OP_CHAR = 1'b0,
    OP_END  = 1'b1
  } op_t;

  // Verdict codes
  typedef enum logic [1:0] {
    VERDICT_NEITHER = 2'd0,
    VERDICT_IPV4    = 2'd1,
    VERDICT_IPV6    = 2'd2
  } verdict_t;

  // Separator characters
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_COLON = 8'h3A;

  // Dotted-decimal limits
  localparam logic [2:0] DOT_MAX_DIGITS = 3'd3;
  localparam logic [9:0] DOT_MAX_VALUE  = 10'd255;
  localparam logic [2:0] DOT_LAST_FIELD = 3'd3;  // separators in a full address

  // Colon-hex limits
  localparam logic [2:0] HEX_MAX_DIGITS = 3'd4;
  localparam logic [3:0] HEX_LAST_FIELD = 4'd7;

  // Item held in the input stage and handed to the checker
  typedef struct packed {
    logic       valid;
    op_t        op;
    logic [7:0] character;
  } step_t;

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_dec(c) || ((c >= 8'h61) && (c <= 8'h66)) || ((c >= 8'h41) && (c <= 8'h46));
  endfunction

endpackage

`default_nettype wire

// ===== src/ipv_if.sv =====
`default_nettype none

// Character channel: one byte of text or the end marker per transfer
interface ipv_text_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] character;

  modport source (output valid, output op, output character, input ready);
  modport sink   (input valid, input op, input character, output ready);
endinterface

// Verdict channel: one transfer per end marker
interface ipv_verdict_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;

  modport source (output valid, output verdict, input ready);
  modport sink   (input valid, input verdict, output ready);
endinterface

`default_nettype wire

// ===== src/ipv_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

module ipv_checker (
  input  logic              clk,
  input  logic              rst,
  input  ipv_pkg::step_t    step,
  output ipv_pkg::verdict_t verdict
);
  import ipv_pkg::*;

  // Scan state
  logic       seen_any_char, seen_any_char_next;
  logic       seen_dot, seen_dot_next;
  logic       seen_colon, seen_colon_next;
  logic       dotted_ok, dotted_ok_next;
  logic [2:0] dotted_field_count, dotted_field_count_next;
  logic [2:0] dotted_field_length, dotted_field_length_next;
  logic [9:0] dotted_field_value, dotted_field_value_next;
  logic       dotted_leading_zero, dotted_leading_zero_next;
  logic       hex_ok, hex_ok_next;
  logic [3:0] hex_field_count, hex_field_count_next;
  logic [2:0] hex_field_length, hex_field_length_next;

  logic [3:0]  digit;
  logic [13:0] value_acc;
  logic [2:0]  dotted_len_sat;
  logic [2:0]  hex_len_sat;
  logic        v4;
  logic        v6;

  // Digit value is the low nibble for '0'..'9'
  assign digit     = step.character[3:0];
  assign value_acc = ({4'd0, dotted_field_value} * 14'd10) + {10'd0, digit};

  // Saturating length increments
  assign dotted_len_sat = (dotted_field_length == 3'd7) ? dotted_field_length
                                                        : dotted_field_length + 3'd1;
  assign hex_len_sat    = (hex_field_length == 3'd7) ? hex_field_length
                                                     : hex_field_length + 3'd1;

  // Next state
  always_comb begin
    seen_any_char_next       = seen_any_char;
    seen_dot_next            = seen_dot;
    seen_colon_next          = seen_colon;
    dotted_ok_next           = dotted_ok;
    dotted_field_count_next  = dotted_field_count;
    dotted_field_length_next = dotted_field_length;
    dotted_field_value_next  = dotted_field_value;
    dotted_leading_zero_next = dotted_leading_zero;
    hex_ok_next              = hex_ok;
    hex_field_count_next     = hex_field_count;
    hex_field_length_next    = hex_field_length;

    if (step.valid) begin
      unique case (step.op)
        OP_CHAR: begin
          seen_any_char_next = 1'b1;
          if (step.character == CHAR_DOT) seen_dot_next = 1'b1;
          if (step.character == CHAR_COLON) seen_colon_next = 1'b1;

          // Dotted-decimal checker
          if (step.character == CHAR_DOT) begin
            if (dotted_field_length == 3'd0) dotted_ok_next = 1'b0;
            if (dotted_field_count != 3'd7) begin
              dotted_field_count_next = dotted_field_count + 3'd1;
            end
            dotted_field_length_next = 3'd0;
            dotted_field_value_next  = 10'd0;
            dotted_leading_zero_next = 1'b0;
          end else if (is_dec(step.character)) begin
            if (dotted_field_length == 3'd0) begin
              if (digit == 4'd0) dotted_leading_zero_next = 1'b1;
            end else if (dotted_leading_zero) begin
              dotted_ok_next = 1'b0;
            end
            if (dotted_field_length < DOT_MAX_DIGITS) begin
              dotted_field_value_next = value_acc[9:0];
              if (value_acc[9:0] > DOT_MAX_VALUE) dotted_ok_next = 1'b0;
            end
            dotted_field_length_next = dotted_len_sat;
            if (dotted_len_sat > DOT_MAX_DIGITS) dotted_ok_next = 1'b0;
          end else begin
            dotted_ok_next = 1'b0;
          end

          // Colon-hex checker
          if (step.character == CHAR_COLON) begin
            if (hex_field_length == 3'd0) hex_ok_next = 1'b0;
            if (hex_field_count != 4'd15) hex_field_count_next = hex_field_count + 4'd1;
            hex_field_length_next = 3'd0;
          end else if (is_hex(step.character)) begin
            hex_field_length_next = hex_len_sat;
            if (hex_len_sat > HEX_MAX_DIGITS) hex_ok_next = 1'b0;
          end else begin
            hex_ok_next = 1'b0;
          end
        end
        OP_END: begin
          // Verdict leaves on this step; start over for the next string
          seen_any_char_next       = 1'b0;
          seen_dot_next            = 1'b0;
          seen_colon_next          = 1'b0;
          dotted_ok_next           = 1'b1;
          dotted_field_count_next  = 3'd0;
          dotted_field_length_next = 3'd0;
          dotted_field_value_next  = 10'd0;
          dotted_leading_zero_next = 1'b0;
          hex_ok_next              = 1'b1;
          hex_field_count_next     = 4'd0;
          hex_field_length_next    = 3'd0;
        end
        default: begin
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_any_char       <= 1'b0;
      seen_dot            <= 1'b0;
      seen_colon          <= 1'b0;
      dotted_ok           <= 1'b1;
      dotted_field_count  <= 3'd0;
      dotted_field_length <= 3'd0;
      dotted_field_value  <= 10'd0;
      dotted_leading_zero <= 1'b0;
      hex_ok              <= 1'b1;
      hex_field_count     <= 4'd0;
      hex_field_length    <= 3'd0;
    end else begin
      seen_any_char       <= seen_any_char_next;
      seen_dot            <= seen_dot_next;
      seen_colon          <= seen_colon_next;
      dotted_ok           <= dotted_ok_next;
      dotted_field_count  <= dotted_field_count_next;
      dotted_field_length <= dotted_field_length_next;
      dotted_field_value  <= dotted_field_value_next;
      dotted_leading_zero <= dotted_leading_zero_next;
      hex_ok              <= hex_ok_next;
      hex_field_count     <= hex_field_count_next;
      hex_field_length    <= hex_field_length_next;
    end
  end

  // Verdict from the state before the end marker
  assign v4 = dotted_ok && (dotted_field_length != 3'd0) &&
              (dotted_field_count == DOT_LAST_FIELD);
  assign v6 = hex_ok && (hex_field_length != 3'd0) && (hex_field_count == HEX_LAST_FIELD);

  always_comb begin
    verdict = VERDICT_NEITHER;
    if (seen_any_char) begin
      priority if (seen_dot) begin
        verdict = v4 ? VERDICT_IPV4 : VERDICT_NEITHER;
      end else if (seen_colon) begin
        verdict = v6 ? VERDICT_IPV6 : VERDICT_NEITHER;
      end else begin
        verdict = VERDICT_NEITHER;
      end
    end
  end

  // Assertions
  `IPV_ASSERT(a_end_clears, step.valid && step.op == OP_END |=> !seen_any_char && dotted_ok && hex_ok, "state not cleared after end marker")
  `IPV_ASSERT(a_seen_sep_needs_char, seen_dot || seen_colon |-> seen_any_char, "separator flag without any character")
  `IPV_ASSERT(a_value_range, dotted_field_value <= 10'd999, "dotted field value out of range")

endmodule

`default_nettype wire

// ===== src/ip_address_text_validator.sv =====
// Checks an address string as IPv4 dotted-decimal and IPv6 colon-hex text at
// the same time. Send one character per transfer on text with op = 0, then a
// transfer with op = 1 to close the string; that end marker alone produces one
// transfer on result: 0 = neither, 1 = valid IPv4, 2 = valid IPv6. A string
// containing '.' is judged as IPv4, otherwise one containing ':' as IPv6;
// an empty string gives neither. Throughput is one item per clock: an input
// register feeds the checker state and a result register, and the input
// register stalls only when an end marker meets a full result register that
// is not being taken. The verdict is offered on result from the result register
// once its end marker leaves the input register, where it waits while blocked.
// Reset is synchronous and active high.
`default_nettype none

`include "assert_macros.svh"

module ip_address_text_validator (
  input  logic               clk,
  input  logic               rst,
  ipv_text_if.sink           text,
  ipv_verdict_if.source      result
);
  import ipv_pkg::*;

  // Input stage
  logic       stage_valid;
  op_t        stage_op;
  logic [7:0] stage_char;
  logic       stage_move;

  // Result register
  logic       out_valid;
  verdict_t   out_verdict;

  step_t      step;
  verdict_t   verdict;

  // The stage drains unless an end marker waits on an occupied result slot
  assign stage_move = stage_valid &&
                      ((stage_op == OP_CHAR) || !out_valid || result.ready);
  assign text.ready = !stage_valid || stage_move;

  // Capture transfers into the input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (text.ready) begin
      stage_valid <= text.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text.ready && text.valid) begin
      stage_op   <= op_t'(text.op);
      stage_char <= text.character;
    end
  end

  assign step.valid     = stage_move;
  assign step.op        = stage_op;
  assign step.character = stage_char;

  ipv_checker u_checker (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .verdict (verdict)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_move && (stage_op == OP_END)) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_move && (stage_op == OP_END)) begin
      out_verdict <= verdict;
    end
  end

  assign result.valid   = out_valid;
  assign result.verdict = out_verdict;

  // Assertions
  `IPV_ASSERT(a_stall_only_on_end, stage_valid && !stage_move |-> stage_op == OP_END, "character item stalled in input stage")
  `IPV_ASSERT(a_end_loads_result, stage_move && stage_op == OP_END |=> out_valid, "end marker did not load a result")
  `IPV_ASSERT(a_backpressure_cause, !text.ready |-> out_valid && !result.ready, "input held off without a blocked result")

endmodule

`default_nettype wire
